// ===== src/bst_pkg.sv =====
// Package for the byte stream tokenizer: token kind codes, character classes,
// keyword tables and the result queue entry type. No dependencies.
`default_nettype none

package bst_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int LEN_BITS = 16;
  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] KIND_LPAREN = 4'd0;
  localparam logic [3:0] KIND_RPAREN = 4'd1;
  localparam logic [3:0] KIND_LBRACE = 4'd2;
  localparam logic [3:0] KIND_RBRACE = 4'd3;
  localparam logic [3:0] KIND_SEMI = 4'd4;
  localparam logic [3:0] KIND_KEYWORD = 4'd5;
  localparam logic [3:0] KIND_IDENT = 4'd6;
  localparam logic [3:0] KIND_NUMBER = 4'd7;
  localparam logic [3:0] KIND_UNKNOWN = 4'd8;
  localparam logic [3:0] KIND_NONE = 4'd15;

  localparam logic [7:0] BYTE_END = 8'h00;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_NL = 8'h0a;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] LETTER_SPAN = 8'd25;

  localparam int KW_COUNT = 3;
  localparam logic [7:0] KW_TEXT [KW_COUNT][6] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n"}
  };
  localparam logic [LEN_BITS-1:0] KW_LEN [KW_COUNT] = '{16'd3, 16'd4, 16'd6};

  typedef struct packed {
    logic [3:0] kind;
    logic [15:0] start;
    logic [15:0] length;
    logic last;
  } token_t;

  function automatic logic is_letter(input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] up;
    lo = b - 8'("a");
    up = b - 8'("A");
    return (lo <= LETTER_SPAN) || (up <= LETTER_SPAN) || (b == 8'("_"));
  endfunction

  function automatic logic is_word_byte(input logic [7:0] b);
    logic [7:0] dg;
    dg = b - 8'("0");
    return is_letter(b) || (dg <= 8'd9);
  endfunction

  function automatic logic [3:0] single_kind(input logic [7:0] b);
    logic [3:0] k;
    unique case (b)
      8'("("): k = KIND_LPAREN;
      8'(")"): k = KIND_RPAREN;
      8'("{"): k = KIND_LBRACE;
      8'("}"): k = KIND_RBRACE;
      8'("["): k = KIND_LBRACE;
      8'("]"): k = KIND_RBRACE;
      8'(";"): k = KIND_SEMI;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [KW_COUNT-1:0] match_update(input logic [KW_COUNT-1:0] bits,
                                                       input logic [LEN_BITS-1:0] pos,
                                                       input logic [7:0] b);
    logic [KW_COUNT-1:0] r;
    r = bits;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (pos >= KW_LEN[k]) begin
        r[k] = 1'b0;
      end else if (KW_TEXT[k][pos[2:0]] != b) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/byte_stream_tokenizer.sv =====
// Byte stream tokenizer: classifies one text byte per beat and queues up to two
// token results per byte in a small result queue. Depends on bst_pkg.
// A result is written to the result queue when its byte is accepted and is offered once it reaches the head.
// Throughput: one byte per cycle while results drain; in_ready drops when the
// four-entry result queue has fewer than two free slots.
// Reset (synchronous, rst high) clears the pending word, offset and queue.
`default_nettype none

module byte_stream_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  text_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       token_kind,
  output logic [15:0]      token_start,
  output logic [15:0]      token_length,
  output logic             last_of_run
);
  import bst_pkg::*;

  logic                   in_word, in_word_next;
  logic                   word_starts_letter, word_starts_letter_next;
  logic [15:0]            word_start, word_start_next;
  logic [LEN_BITS-1:0]    word_length, word_length_next;
  logic [KW_COUNT-1:0]    keyword_still_matching, keyword_still_matching_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;

  token_t                 queue [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0]   count;

  token_t                 res0, res1;
  logic [1:0]             n_res;
  logic                   in_fire, out_fire;
  logic [15:0]            offset16;
  logic [3:0]             sk;
  logic [3:0]             wkind;

  assign in_ready = (count <= QCNT_BITS'(QUEUE_DEPTH - 2));
  assign in_fire = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_fire = out_valid && out_ready;
  assign offset16 = 16'(byte_offset);
  assign sk = single_kind(text_byte);

  always_comb begin
    wkind = word_starts_letter ? KIND_IDENT : KIND_NUMBER;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (keyword_still_matching[k] && (word_length == KW_LEN[k])) begin
        wkind = KIND_KEYWORD;
      end
    end
  end

  always_comb begin
    in_word_next = in_word;
    word_starts_letter_next = word_starts_letter;
    word_start_next = word_start;
    word_length_next = word_length;
    keyword_still_matching_next = keyword_still_matching;
    byte_offset_next = byte_offset;
    n_res = 2'd0;
    res0 = '{kind: wkind, start: word_start, length: word_length, last: 1'b0};
    res1 = '{kind: KIND_UNKNOWN, start: offset16, length: 16'd1, last: 1'b0};

    if (in_word && is_word_byte(text_byte)) begin
      keyword_still_matching_next = match_update(keyword_still_matching, word_length,
                                                 text_byte);
      if (word_length < LEN_MAX) begin
        word_length_next = word_length + 1'b1;
      end
    end else begin
      if (in_word) begin
        n_res = 2'd1;
        in_word_next = 1'b0;
        word_starts_letter_next = 1'b0;
        word_start_next = '0;
        word_length_next = '0;
        keyword_still_matching_next = '1;
      end
      priority if (text_byte == BYTE_END) begin
      end else if (text_byte == BYTE_SPACE || text_byte == BYTE_TAB ||
                   text_byte == BYTE_NL) begin
      end else if (sk != KIND_NONE) begin
        if (in_word) begin
          res1.kind = sk;
          n_res = 2'd2;
        end else begin
          res0 = '{kind: sk, start: offset16, length: 16'd1, last: 1'b0};
          n_res = 2'd1;
        end
      end else if (is_word_byte(text_byte)) begin
        in_word_next = 1'b1;
        word_starts_letter_next = is_letter(text_byte);
        word_start_next = offset16;
        word_length_next = 16'd1;
        keyword_still_matching_next = match_update('1, '0, text_byte);
      end else begin
        if (in_word) begin
          n_res = 2'd2;
        end else begin
          res0 = res1;
          n_res = 2'd1;
        end
      end
    end

    if (n_res == 2'd1) begin
      res0.last = 1'b1;
    end else begin
      res1.last = 1'b1;
    end

    if (text_byte == BYTE_END) begin
      byte_offset_next = '0;
    end else if (byte_offset != '1) begin
      byte_offset_next = byte_offset + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_word <= 1'b0;
      word_starts_letter <= 1'b0;
      word_start <= '0;
      word_length <= '0;
      keyword_still_matching <= '1;
      byte_offset <= '0;
    end else if (in_fire) begin
      in_word <= in_word_next;
      word_starts_letter <= word_starts_letter_next;
      word_start <= word_start_next;
      word_length <= word_length_next;
      keyword_still_matching <= keyword_still_matching_next;
      byte_offset <= byte_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && n_res != 2'd0) begin
      queue[wr_ptr] <= res0;
      if (n_res == 2'd2) begin
        queue[wr_ptr + 1'b1] <= res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(n_res);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_BITS'(in_fire ? n_res : 2'd0) - QCNT_BITS'(out_fire);
    end
  end

  assign token_kind = queue[rd_ptr].kind;
  assign token_start = queue[rd_ptr].start;
  assign token_length = queue[rd_ptr].length;
  assign last_of_run = queue[rd_ptr].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && text_byte == BYTE_END) |=> (byte_offset == '0 && !in_word))
    else $error("end of text did not clear state");

  a_word_len: assert property (@(posedge clk) disable iff (rst)
    in_word |-> (word_length != '0))
    else $error("pending word with zero length");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_fire && count == QCNT_BITS'(1) && !in_fire) |=> !out_valid)
    else $error("queue not empty after last result taken");

endmodule

`default_nettype wire

// ===== dv/byte_stream_tokenizer_checker.sv =====
// Checker for the byte stream tokenizer: watches the text and token channels,
// predicts the token beats from the accepted text bytes and compares them.
// Depends on bst_pkg for the token kind codes, byte codes and token_t.
`timescale 1ns / 100ps

module byte_stream_tokenizer_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  text_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [3:0]  token_kind,
  input  wire logic [15:0] token_start,
  input  wire logic [15:0] token_length,
  input  wire logic        last_of_run,
  output int               fail_count,
  output int               pending_tokens,
  output int               bytes_seen,
  output int               tokens_seen
);

  import bst_pkg::*;

  logic                   in_word;
  logic                   name_word;
  logic [15:0]            word_start;
  logic [15:0]            word_len;
  logic [47:0]            word_head;
  logic [OFFSET_BITS-1:0] next_offset;
  token_t                 expected_tokens[$];
  int                     errors = 0;
  int                     byte_total = 0;
  int                     token_total = 0;

  function automatic logic starts_name(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic joins_word(input logic [7:0] b);
    return starts_name(b) || (b >= "0" && b <= "9");
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] b);
    case (b)
      "(": return KIND_LPAREN;
      ")": return KIND_RPAREN;
      "{", "[": return KIND_LBRACE;
      "}", "]": return KIND_RBRACE;
      ";": return KIND_SEMI;
      default: return KIND_NONE;
    endcase
  endfunction

  function automatic logic [3:0] finished_word_kind();
    if ((word_len == 16'd3 && word_head[47:24] == "int") ||
        (word_len == 16'd4 && word_head[47:16] == "void") ||
        (word_len == 16'd6 && word_head == "return")) begin
      return KIND_KEYWORD;
    end
    return name_word ? KIND_IDENT : KIND_NUMBER;
  endfunction

  task automatic clear_word();
    in_word = 1'b0;
    name_word = 1'b0;
    word_start = '0;
    word_len = '0;
    word_head = '0;
  endtask

  task automatic push_token(input logic [3:0] kind, input logic [15:0] start,
                            input logic [15:0] len);
    token_t t;
    t.kind = kind;
    t.start = start;
    t.length = len;
    t.last = 1'b0;
    expected_tokens.push_back(t);
  endtask

  task automatic predict_byte(input logic [7:0] b);
    int     queued;
    logic [3:0] single;
    token_t t;
    queued = expected_tokens.size();
    single = punct_kind(b);
    if (in_word && joins_word(b)) begin
      if (word_len < 16'd6) begin
        word_head[47 - 8 * int'(word_len) -: 8] = b;
      end
      if (word_len != LEN_MAX) begin
        word_len = word_len + 16'd1;
      end
    end else begin
      if (in_word) begin
        push_token(finished_word_kind(), word_start, word_len);
        clear_word();
      end
      if (b == BYTE_END || b == BYTE_SPACE || b == BYTE_TAB || b == BYTE_NL) begin
      end else if (single != KIND_NONE) begin
        push_token(single, 16'(next_offset), 16'd1);
      end else if (joins_word(b)) begin
        in_word = 1'b1;
        name_word = starts_name(b);
        word_start = 16'(next_offset);
        word_len = 16'd1;
        word_head = {b, 40'd0};
      end else begin
        push_token(KIND_UNKNOWN, 16'(next_offset), 16'd1);
      end
    end
    if (b == BYTE_END) begin
      next_offset = '0;
    end else if (next_offset != '1) begin
      next_offset = next_offset + 1'b1;
    end
    if (expected_tokens.size() > queued) begin
      t = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.push_back(t);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    token_t want;
    if (rst) begin
      clear_word();
      next_offset = '0;
      expected_tokens.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_byte(text_byte);
        byte_total++;
      end
      if (out_valid && out_ready) begin
        token_total++;
        if (expected_tokens.size() == 0) begin
          $error("token beat with none expected: kind %0d, start %0d, length %0d",
                 token_kind, token_start, token_length);
          errors++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_kind", 32'(want.kind), 32'(token_kind));
          check_field("token_start", 32'(want.start), 32'(token_start));
          check_field("token_length", 32'(want.length), 32'(token_length));
          check_field("last_of_run", 32'(want.last), 32'(last_of_run));
        end
      end
    end
    fail_count <= errors + expected_tokens.size();
    pending_tokens <= expected_tokens.size();
    bytes_seen <= byte_total;
    tokens_seen <= token_total;
  end

endmodule

// ===== dv/byte_stream_tokenizer_tb.sv =====
// Testbench top for the byte stream tokenizer: clock, reset, text stimulus with
// several stall mixes, and the verdict. Depends on bst_pkg, the block and the
// byte_stream_tokenizer_checker module.
`timescale 1ns / 100ps

module byte_stream_tokenizer_tb;

  import bst_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_BYTES = 800;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  text_byte = 8'd0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;

  int fail_count;
  int pending_tokens;
  int bytes_seen;
  int tokens_seen;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int counted = 0;
  int cycles = 0;

  byte_stream_tokenizer u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

  byte_stream_tokenizer_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .text_byte      (text_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .token_kind     (token_kind),
    .token_start    (token_start),
    .token_length   (token_length),
    .last_of_run    (last_of_run),
    .fail_count     (fail_count),
    .pending_tokens (pending_tokens),
    .bytes_seen     (bytes_seen),
    .tokens_seen    (tokens_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    counted++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_tokens != 0) @(posedge clk);
  endtask

  function automatic string keyword_text(input int idx);
    case (idx)
      0: return "int";
      1: return "void";
      default: return "return";
    endcase
  endfunction

  function automatic logic [7:0] name_char();
    int r;
    r = $urandom_range(52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(62);
    if (r < 53) return name_char();
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] punct_char();
    case ($urandom_range(6))
      0: return "(";
      1: return ")";
      2: return "{";
      3: return "}";
      4: return "[";
      5: return "]";
      default: return ";";
    endcase
  endfunction

  task automatic send_fragment();
    int    pick;
    int    cut;
    string word;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_text(keyword_text($urandom_range(2)));
    end else if (pick < 25) begin
      word = keyword_text($urandom_range(2));
      if ($urandom_range(1) == 0) begin
        cut = $urandom_range(word.len() - 1, 1);
        for (int i = 0; i < cut; i++) begin
          send_byte(word[i]);
        end
      end else begin
        send_text(word);
        send_byte(word_char());
      end
    end else if (pick < 45) begin
      send_byte(name_char());
      repeat ($urandom_range(7)) send_byte(word_char());
    end else if (pick < 55) begin
      send_byte(8'("0" + $urandom_range(9)));
      repeat ($urandom_range(5)) send_byte(word_char());
    end else if (pick < 70) begin
      send_byte(punct_char());
    end else if (pick < 85) begin
      case ($urandom_range(2))
        0: send_byte(BYTE_SPACE);
        1: send_byte(BYTE_TAB);
        default: send_byte(BYTE_NL);
      endcase
    end else if (pick < 90) begin
      send_byte(BYTE_END);
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text("int(void)return;9 {}[]\t@");
    send_byte(8'hff);
    send_text("\n_");
    send_byte(BYTE_END);
    send_byte(BYTE_END);
    hold_until_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 52;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 52;
        end
        default: begin
          send_idle_pct = 12;
          recv_stall_pct = 12;
        end
      endcase
      counted = 0;
      while (counted < RANDOM_BYTES / 4) send_fragment();
      hold_until_drained();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_byte(BYTE_END);
    send_text(";(int)");
    repeat (10) send_fragment();
    send_byte(BYTE_END);
    send_text("return");
    send_byte(BYTE_END);
    hold_until_drained();
    repeat (10) @(posedge clk);

    $display("Checked %0d token beats from %0d text bytes.", tokens_seen, bytes_seen);
    $display("Directed tokens and random text under four stall mixes were run.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== byte_stream_tokenizer.f =====
src/bst_pkg.sv
src/byte_stream_tokenizer.sv
dv/byte_stream_tokenizer_checker.sv
dv/byte_stream_tokenizer_tb.sv
